// File: rtl/wtc_pkg.sv
// wtc_pkg: shared types, codes and constants for the winder traverse controller
// used by every rtl file of the block, no dependencies

package wtc_pkg;

  localparam int unsigned PosW      = 16;
  localparam int unsigned StepW     = 10;
  localparam int unsigned DistW     = 15;
  localparam int unsigned StallW    = 10;
  localparam int unsigned IgnoreW   = 8;
  localparam int unsigned OpW       = 3;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;

  localparam logic [StepW-1:0]   StepSizeRst   = StepW'(100);
  localparam logic [DistW-1:0]   MaxDistRst    = DistW'(16000);
  localparam logic [StallW-1:0]  StallThrRst   = StallW'(100);
  localparam logic [IgnoreW-1:0] IgnoreTickRst = IgnoreW'(10);

  typedef enum logic [1:0] {
    REG_STEP_SIZE   = 2'd0,
    REG_MAX_DIST    = 2'd1,
    REG_STALL_THR   = 2'd2,
    REG_IGNORE_TICK = 2'd3
  } reg_idx_t;

  typedef enum logic [OpW-1:0] {
    OP_HOME_TICK = 3'd0,
    OP_TURN      = 3'd1,
    OP_CLICK     = 3'd2,
    OP_REV       = 3'd3,
    OP_START     = 3'd4,
    OP_RESET     = 3'd5
  } opcode_t;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_START = 4'b0010,
    MODE_END   = 4'b0100,
    MODE_RUN   = 4'b1000
  } mode_t;

  localparam logic [ModeW-1:0] ModeCodeIdle  = 2'd0;
  localparam logic [ModeW-1:0] ModeCodeStart = 2'd1;
  localparam logic [ModeW-1:0] ModeCodeEnd   = 2'd2;
  localparam logic [ModeW-1:0] ModeCodeRun   = 2'd3;

  typedef struct packed {
    logic [StepW-1:0]   step_size;
    logic [DistW-1:0]   max_distance;
    logic [StallW-1:0]  stall_threshold;
    logic [IgnoreW-1:0] stall_ignore_ticks;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [StallW-1:0] stall_value;
    logic              turn_up;
  } item_t;

  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic                   is_homed;
    logic [ModeW-1:0]       mode;
    logic                   moving_backward;
    logic                   moved;
  } result_t;

  function automatic logic [ModeW-1:0] mode_code(input mode_t m);
    logic [ModeW-1:0] c;
    c = ModeCodeIdle;
    unique case (m)
      MODE_IDLE:  c = ModeCodeIdle;
      MODE_START: c = ModeCodeStart;
      MODE_END:   c = ModeCodeEnd;
      MODE_RUN:   c = ModeCodeRun;
      default:    c = ModeCodeIdle;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/winder_traverse_controller_core.sv
// winder_traverse_controller_core: top level of the spool traverse controller
// depends on wtc_pkg, wtc_cfg_regs and wtc_state
//
// Takes one event transaction per cycle while out_ready stays high and returns
// one result transaction per event, in order. An event is held in an input
// register, its state update is done by add and compare logic, and the result
// lands in an output register, whose load can wait while an earlier result is
// stalled; out_valid rises as it is loaded. The user must write configuration
// registers through the apb port only while no transaction is in flight; the
// block itself does not enforce this.

module winder_traverse_controller_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wtc_pkg::OpW-1:0]        in_opcode,
  input  logic [wtc_pkg::StallW-1:0]     in_stall_value,
  input  logic                           in_turn_up,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [wtc_pkg::PosW-1:0] out_position,
  output logic                           out_is_homed,
  output logic [wtc_pkg::ModeW-1:0]      out_mode,
  output logic                           out_moving_backward,
  output logic                           out_moved,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wtc_pkg::AddrW-1:0]      paddr,
  input  logic [wtc_pkg::DataW-1:0]      pwdata,
  output logic [wtc_pkg::DataW-1:0]      prdata,
  output logic                           pready
);
  import wtc_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_vld_r;
  result_t res;
  result_t res_r;
  logic    res_vld_r;
  logic    advance;

  wtc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wtc_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (item_r),
    .fire  (advance),
    .res   (res)
  );

  assign advance  = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_ready) item_vld_r <= in_valid;
      if (advance) res_vld_r <= 1'b1;
      else if (out_ready) res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.opcode      <= in_opcode;
      item_r.stall_value <= in_stall_value;
      item_r.turn_up     <= in_turn_up;
    end
    if (advance) res_r <= res;
  end

  assign out_valid           = res_vld_r;
  assign out_position        = res_r.position;
  assign out_is_homed        = res_r.is_homed;
  assign out_mode            = res_r.mode;
  assign out_moving_backward = res_r.moving_backward;
  assign out_moved           = res_r.moved;

endmodule

// File: rtl/wtc_cfg_regs.sv
// wtc_cfg_regs: apb-style configuration registers of the traverse controller
// depends on wtc_pkg

module wtc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wtc_pkg::AddrW-1:0]   paddr,
  input  logic [wtc_pkg::DataW-1:0]   pwdata,
  output logic [wtc_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output wtc_pkg::cfg_t               cfg
);
  import wtc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_size          <= StepSizeRst;
      cfg_r.max_distance       <= MaxDistRst;
      cfg_r.stall_threshold    <= StallThrRst;
      cfg_r.stall_ignore_ticks <= IgnoreTickRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_STEP_SIZE:   cfg_r.step_size          <= pwdata[StepW-1:0];
        REG_MAX_DIST:    cfg_r.max_distance       <= pwdata[DistW-1:0];
        REG_STALL_THR:   cfg_r.stall_threshold    <= pwdata[StallW-1:0];
        REG_IGNORE_TICK: cfg_r.stall_ignore_ticks <= pwdata[IgnoreW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_STEP_SIZE:   prdata = DataW'(cfg_r.step_size);
      REG_MAX_DIST:    prdata = DataW'(cfg_r.max_distance);
      REG_STALL_THR:   prdata = DataW'(cfg_r.stall_threshold);
      REG_IGNORE_TICK: prdata = DataW'(cfg_r.stall_ignore_ticks);
      default:         prdata = '0;
    endcase
  end

endmodule

// File: rtl/wtc_state.sv
// wtc_state: homing, positioning and running state with its one-step update
// depends on wtc_pkg

module wtc_state (
  input  logic              clk,
  input  logic              rst_n,
  input  wtc_pkg::cfg_t     cfg,
  input  wtc_pkg::item_t    item,
  input  logic              fire,
  output wtc_pkg::result_t  res
);
  import wtc_pkg::*;

  logic                 homed_r, homed_nxt;
  logic [IgnoreW-1:0]   ign_r, ign_nxt;
  mode_t                mode_r, mode_nxt;
  logic [PosW-1:0]      pos_r, pos_nxt;
  logic [PosW-1:0]      end_r, end_nxt;
  logic                 back_r, back_nxt;

  logic signed [PosW+1:0] tgt;
  logic signed [PosW+1:0] tgt_neg;
  logic                   tgt_ok;
  logic [PosW-1:0]        run_pos;
  logic                   edit_mode;

  always_comb begin
    if (item.turn_up)
      tgt = $signed({{2{pos_r[PosW-1]}}, pos_r}) - $signed({8'd0, cfg.step_size});
    else
      tgt = $signed({{2{pos_r[PosW-1]}}, pos_r}) + $signed({8'd0, cfg.step_size});
    tgt_neg = -tgt;
    tgt_ok  = (tgt <= 0) && (tgt_neg <= $signed({3'd0, cfg.max_distance}));
    run_pos = back_r ? pos_r + PosW'(cfg.step_size) : pos_r - PosW'(cfg.step_size);
  end

  assign edit_mode = (mode_r == MODE_START) || (mode_r == MODE_END);

  always_comb begin
    homed_nxt = homed_r;
    ign_nxt   = ign_r;
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    end_nxt   = end_r;
    back_nxt  = back_r;
    unique case (opcode_t'(item.opcode))
      OP_HOME_TICK: begin
        if (!homed_r) begin
          if (ign_r < cfg.stall_ignore_ticks) begin
            ign_nxt = ign_r + 1'b1;
          end else if (item.stall_value < cfg.stall_threshold) begin
            homed_nxt = 1'b1;
            pos_nxt   = '0;
          end
        end
      end
      OP_TURN: begin
        if (homed_r && edit_mode && tgt_ok) begin
          pos_nxt = tgt[PosW-1:0];
        end
      end
      OP_CLICK: begin
        if (homed_r && mode_r == MODE_START) begin
          pos_nxt  = '0;
          mode_nxt = MODE_END;
        end else if (homed_r && mode_r == MODE_END) begin
          end_nxt  = pos_r;
          pos_nxt  = '0;
          mode_nxt = MODE_RUN;
        end
      end
      OP_REV: begin
        if (homed_r && mode_r == MODE_RUN) begin
          pos_nxt = run_pos;
          if ($signed(run_pos) <= $signed(end_r)) back_nxt = 1'b1;
          if (!run_pos[PosW-1]) back_nxt = 1'b0;
        end
      end
      OP_START: begin
        if (homed_r) begin
          end_nxt  = '0;
          mode_nxt = MODE_START;
        end
      end
      OP_RESET: begin
        homed_nxt = 1'b0;
        ign_nxt   = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.position        = $signed(pos_nxt);
    res.is_homed        = homed_nxt;
    res.mode            = mode_code(mode_nxt);
    res.moving_backward = back_nxt;
    res.moved           = (pos_nxt != pos_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      homed_r <= 1'b0;
      ign_r   <= '0;
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      end_r   <= '0;
      back_r  <= 1'b0;
    end else if (fire) begin
      homed_r <= homed_nxt;
      ign_r   <= ign_nxt;
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      end_r   <= end_nxt;
      back_r  <= back_nxt;
    end
  end

endmodule

// File: rtl/wtc_checker.sv
// wtc_checker: port-level assertions for the traverse controller, bound to the top
// depends on wtc_pkg and winder_traverse_controller_core

module wtc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [wtc_pkg::PosW-1:0] out_position,
  input logic                            out_is_homed,
  input logic [wtc_pkg::ModeW-1:0]       out_mode,
  input logic                            out_moving_backward,
  input logic                            out_moved
);
  import wtc_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position)
      && $stable(out_is_homed) && $stable(out_mode)
      && $stable(out_moving_backward) && $stable(out_moved))
    else $error("stalled result transaction changed");

  a_unhomed_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_homed |-> !out_moved)
    else $error("position moved while not homed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind winder_traverse_controller_core wtc_checker u_wtc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_position        (out_position),
  .out_is_homed        (out_is_homed),
  .out_mode            (out_mode),
  .out_moving_backward (out_moving_backward),
  .out_moved           (out_moved)
);
